// ===== rtl/core/bsd_pkg.sv =====
// Shared types and constants for the bounded shift deque.
`default_nettype none
package bsd_pkg;

  localparam int DEPTH = 16;
  localparam int DATA_W = 32;
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int CFG_W = 5;
  localparam int OP_W = 3;
  localparam int ST_W = 2;
  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ_ALL   = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_LOAD,
    CMD_SHIFT_UP,
    CMD_SHIFT_DOWN,
    CMD_ROTATE
  } cell_cmd_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_READ
  } fsm_t;

  // Row-wide control: broadcast command plus per-cell position flags.
  typedef struct packed {
    cell_cmd_t        cmd;
    logic [DEPTH-1:0] slot;
    logic [DEPTH-1:0] tail;
  } row_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/bsd_cell.sv =====
// One storage cell of the deque row.
`default_nettype none
module bsd_cell (
  input  wire logic                       clk,
  input  wire bsd_pkg::cell_cmd_t         cmd,
  input  wire logic                       at_slot,
  input  wire logic                       at_tail,
  input  wire logic [bsd_pkg::DATA_W-1:0] push_data,
  input  wire logic [bsd_pkg::DATA_W-1:0] prev_q,
  input  wire logic [bsd_pkg::DATA_W-1:0] next_q,
  input  wire logic [bsd_pkg::DATA_W-1:0] head_q,
  output logic      [bsd_pkg::DATA_W-1:0] q
);

  logic [bsd_pkg::DATA_W-1:0] data_r;
  logic [bsd_pkg::DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (cmd)
      bsd_pkg::CMD_HOLD:       data_nxt = data_r;
      bsd_pkg::CMD_LOAD:       data_nxt = at_slot ? push_data : data_r;
      bsd_pkg::CMD_SHIFT_UP:   data_nxt = prev_q;
      bsd_pkg::CMD_SHIFT_DOWN: data_nxt = next_q;
      // wrap the front entry round to the tail so the list survives a read-out
      bsd_pkg::CMD_ROTATE:     data_nxt = at_tail ? head_q : next_q;
      default:                 data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule
`default_nettype wire

// ===== rtl/core/bsd_ctrl.sv =====
// Sequencer: occupancy, capacity register, read-out stream and result register.
`default_nettype none
module bsd_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [bsd_pkg::OP_W-1:0]    in_op,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [bsd_pkg::CFG_W-1:0]   cfg_capacity_limit,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [bsd_pkg::ST_W-1:0]         out_status,
  output logic [bsd_pkg::DATA_W-1:0]       out_element,
  output logic                             out_last,
  input  wire logic [bsd_pkg::DATA_W-1:0]  head_q,
  output bsd_pkg::row_ctl_t                row_ctl
);

  bsd_pkg::fsm_t                 state_r, state_nxt;
  logic [bsd_pkg::OCC_W-1:0]     occ_r, occ_nxt;
  logic [bsd_pkg::OCC_W-1:0]     rd_cnt_r, rd_cnt_nxt;
  logic [bsd_pkg::CFG_W-1:0]     cap_r;
  logic                          out_valid_r, out_valid_nxt;
  bsd_pkg::status_t              status_r, status_nxt;
  logic [bsd_pkg::DATA_W-1:0]    elem_r, elem_nxt;
  logic                          last_r, last_nxt;
  logic                          slot_free;
  logic                          take;
  logic                          room;
  logic                          rd_last;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == bsd_pkg::FSM_IDLE) && slot_free;
  assign take      = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign room      = (32'(occ_r) < 32'(cap_r)) && (32'(occ_r) < bsd_pkg::DEPTH);
  assign rd_last   = (rd_cnt_r == occ_r - bsd_pkg::OCC_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsd_pkg::FSM_IDLE;
      occ_r       <= '0;
      rd_cnt_r    <= '0;
      cap_r       <= bsd_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_capacity_limit;
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    elem_r   <= elem_nxt;
    last_r   <= last_nxt;
  end

  always_comb begin
    for (int i = 0; i < bsd_pkg::DEPTH; i++) begin
      row_ctl.slot[i] = (occ_r == bsd_pkg::OCC_W'(i));
      row_ctl.tail[i] = (occ_r == bsd_pkg::OCC_W'(i + 1));
    end
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    rd_cnt_nxt    = rd_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    elem_nxt      = elem_r;
    last_nxt      = last_r;
    row_ctl.cmd   = bsd_pkg::CMD_HOLD;
    unique case (state_r)
      bsd_pkg::FSM_IDLE: begin
        if (take) begin
          out_valid_nxt = 1'b1;
          status_nxt    = bsd_pkg::ST_OK;
          elem_nxt      = '0;
          last_nxt      = 1'b1;
          unique case (bsd_pkg::op_t'(in_op))
            bsd_pkg::OP_PUSH_FRONT, bsd_pkg::OP_PUSH_BACK: begin
              if (room) begin
                row_ctl.cmd = (bsd_pkg::op_t'(in_op) == bsd_pkg::OP_PUSH_FRONT)
                            ? bsd_pkg::CMD_SHIFT_UP : bsd_pkg::CMD_LOAD;
                occ_nxt     = occ_r + bsd_pkg::OCC_W'(1);
              end else begin
                status_nxt = bsd_pkg::ST_FULL;
              end
            end
            bsd_pkg::OP_POP_FRONT, bsd_pkg::OP_POP_BACK: begin
              if (occ_r != '0) begin
                if (bsd_pkg::op_t'(in_op) == bsd_pkg::OP_POP_FRONT) begin
                  row_ctl.cmd = bsd_pkg::CMD_SHIFT_DOWN;
                end
                occ_nxt = occ_r - bsd_pkg::OCC_W'(1);
              end else begin
                status_nxt = bsd_pkg::ST_EMPTY;
              end
            end
            bsd_pkg::OP_READ_ALL: begin
              if (occ_r == '0) begin
                status_nxt = bsd_pkg::ST_EMPTY;
              end else begin
                // stream from the next cycle on
                out_valid_nxt = 1'b0;
                rd_cnt_nxt    = '0;
                state_nxt     = bsd_pkg::FSM_READ;
              end
            end
            default: begin
              // drop unused codes without a result
              out_valid_nxt = 1'b0;
            end
          endcase
        end
      end
      bsd_pkg::FSM_READ: begin
        if (slot_free) begin
          row_ctl.cmd   = bsd_pkg::CMD_ROTATE;
          out_valid_nxt = 1'b1;
          status_nxt    = bsd_pkg::ST_OK;
          elem_nxt      = head_q;
          last_nxt      = rd_last;
          rd_cnt_nxt    = rd_cnt_r + bsd_pkg::OCC_W'(1);
          if (rd_last) begin
            state_nxt = bsd_pkg::FSM_IDLE;
          end
        end
      end
      default: state_nxt = bsd_pkg::FSM_IDLE;
    endcase
  end

  assign out_valid   = out_valid_r;
  assign out_status  = status_r;
  assign out_element = elem_r;
  assign out_last    = last_r;

endmodule
`default_nettype wire

// ===== rtl/core/bounded_shift_deque.sv =====
// Bounded shift deque: sequencer plus a row of shifting storage cells.
// Push and pop requests: result registered in the cycle after acceptance; a new
// request is taken every cycle while the result register drains.
// Read all: the sequencer enters the stream state, then gives one entry per cycle
// while the result register drains, front first, each step rotating the cell row by one.
// Reset (rst_n low, synchronous) empties the list, sets capacity to 16 and
// clears the result valid; cell contents stay undefined until written.
`default_nettype none
module bounded_shift_deque (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [bsd_pkg::OP_W-1:0]    in_op,
  input  wire logic signed [bsd_pkg::DATA_W-1:0] in_value,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [bsd_pkg::CFG_W-1:0]   cfg_capacity_limit,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [bsd_pkg::ST_W-1:0]         out_status,
  output logic signed [bsd_pkg::DATA_W-1:0] out_element,
  output logic                             out_last
);

  bsd_pkg::row_ctl_t          row_ctl;
  logic [bsd_pkg::DATA_W-1:0] cell_q [bsd_pkg::DEPTH];
  logic [bsd_pkg::DATA_W-1:0] elem;

  bsd_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_capacity_limit (cfg_capacity_limit),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_element        (elem),
    .out_last           (out_last),
    .head_q             (cell_q[0]),
    .row_ctl            (row_ctl)
  );

  assign out_element = $signed(elem);

  for (genvar i = 0; i < bsd_pkg::DEPTH; i++) begin : g_cell
    logic [bsd_pkg::DATA_W-1:0] prev_q;
    logic [bsd_pkg::DATA_W-1:0] next_q;
    if (i == 0) begin : g_first
      assign prev_q = in_value;
    end else begin : g_mid
      assign prev_q = cell_q[i-1];
    end
    if (i == bsd_pkg::DEPTH - 1) begin : g_end
      assign next_q = cell_q[i];
    end else begin : g_inner
      assign next_q = cell_q[i+1];
    end
    bsd_cell u_cell (
      .clk       (clk),
      .cmd       (row_ctl.cmd),
      .at_slot   (row_ctl.slot[i]),
      .at_tail   (row_ctl.tail[i]),
      .push_data (in_value),
      .prev_q    (prev_q),
      .next_q    (next_q),
      .head_q    (cell_q[0]),
      .q         (cell_q[i])
    );
  end

endmodule
`default_nettype wire

// ===== rtl/core/bsd_chk.sv =====
// Port-level checker for the bounded shift deque, bound to the top level.
`default_nettype none
module bsd_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic [bsd_pkg::OP_W-1:0]    in_op,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [bsd_pkg::ST_W-1:0]    out_status,
  input wire logic [bsd_pkg::DATA_W-1:0]  out_element,
  input wire logic                        out_last
);

  a_push_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_op == 3'(bsd_pkg::OP_PUSH_FRONT)
      || in_op == 3'(bsd_pkg::OP_PUSH_BACK) || in_op == 3'(bsd_pkg::OP_POP_FRONT)
      || in_op == 3'(bsd_pkg::OP_POP_BACK)))
    |=> out_valid)
    else $error("push or pop request gave no result");

  a_no_take_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("request taken while result stalled");

  a_error_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != 2'(bsd_pkg::ST_OK)) |-> (out_last && out_element == '0))
    else $error("error result not final or carries data");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_element) && $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind bounded_shift_deque bsd_chk u_bsd_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .in_op       (in_op),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_status  (out_status),
  .out_element (out_element),
  .out_last    (out_last)
);
`default_nettype wire
